/* rtl/tts_pkg.sv */
// Shared types and constants for the tick task release scheduler.
// Used by tts_ctrl, tts_dp and tick_task_release_scheduler_core.
package tts_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_RES       = 8;
	localparam int CNT_W         = 4;

	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	typedef struct packed {
		logic [7:0]  runs;
		logic        coop;
		logic [15:0] period;
		logic [15:0] delay;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        last;
		logic        occ;
		logic [15:0] delay;
		logic [7:0]  runs;
		logic        now;
		logic        due;
		logic [2:0]  slot;
	} res_t;

	typedef struct packed {
		logic take;
		logic issue;
		logic flush;
		logic acc_rd;
		logic acc_out;
	} cmd_t;

	typedef struct packed {
		logic stall;
		logic hold_vld;
		logic out_free;
	} sts_t;

endpackage

/* rtl/tts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/tts_ctrl.sv */
// Sequencer for tick walks and slot accesses.
// Depends on tts_pkg; drives tts_dp through cmd_t and reads sts_t.
module tts_ctrl #(
	parameter int NUM_SLOTS = 8,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  logic [1:0]     in_func,
	input  tts_pkg::sts_t  sts,
	output tts_pkg::cmd_t  cmd,
	output logic [IW-1:0]  walk_addr
);

	import tts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_WTAIL,
		S_FLUSH,
		S_ACC_RD,
		S_ACC_OUT
	} state_t;

	state_t        state_q;
	logic [IW-1:0] idx_q;
	logic          rdy_q;

	always_comb begin
		cmd         = '0;
		cmd.take    = s_valid & rdy_q;
		cmd.issue   = (state_q == S_WALK);
		cmd.flush   = (state_q == S_FLUSH);
		cmd.acc_rd  = (state_q == S_ACC_RD);
		cmd.acc_out = (state_q == S_ACC_OUT);
	end

	assign walk_addr = idx_q;
	assign s_ready   = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.take) begin
						if (in_func == FN_TICK) begin
							state_q <= S_WALK;
							idx_q   <= '0;
							rdy_q   <= 1'b0;
						end else if (in_func inside {FN_WRITE, FN_READ}) begin
							state_q <= S_ACC_RD;
							rdy_q   <= 1'b0;
						end
					end
				end
				S_WALK: begin
					if (!sts.stall) begin
						if (idx_q == IW'(NUM_SLOTS - 1)) begin
							state_q <= S_WTAIL;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_WTAIL: begin
					if (!sts.stall) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!sts.hold_vld || sts.out_free) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				S_ACC_RD: begin
					state_q <= S_ACC_OUT;
				end
				S_ACC_OUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/tts_dp.sv */
// Slot table, walk stage, held result and output register.
// Depends on tts_pkg and tts_ram; commanded by tts_ctrl.
module tts_dp #(
	parameter int NUM_SLOTS = 8,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tts_pkg::cmd_t  cmd,
	input  logic [IW-1:0]  walk_addr,
	output tts_pkg::sts_t  sts,
	input  logic [1:0]     in_func,
	input  logic [2:0]     in_slot,
	input  logic [15:0]    in_delay,
	input  logic [15:0]    in_period,
	input  logic           in_coop,
	input  logic           in_occ,
	output logic           out_valid,
	input  logic           out_ready,
	output tts_pkg::res_t  out_res
);

	import tts_pkg::*;

	// request fields held for the access sequence
	logic [1:0]  it_func_q;
	logic [2:0]  it_slot_q;
	logic [15:0] it_delay_q;
	logic [15:0] it_period_q;
	logic        it_coop_q;
	logic        it_occ_q;

	logic [NUM_SLOTS-1:0] valid_q;
	logic                 p_vld_s1;
	logic [IW-1:0]        p_idx_s1;
	logic [CNT_W-1:0]     cnt_q;
	logic                 hold_vld_q;
	res_t                 hold_q;
	logic                 out_vld_q;
	res_t                 out_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IW-1:0]      ram_waddr;
	logic [IW-1:0]      ram_raddr;
	logic               ram_we;
	logic               ram_re;

	logic    [IW-1:0] it_idx;
	logic             in_range;
	entry_t           ent;
	entry_t           nxt;
	logic             nxt_valid;
	logic             v;
	logic             dec;
	logic             rel;
	logic             emit;
	logic             out_free;
	logic             stall;
	logic             adv;
	logic             acc_wr;
	res_t             rel_res;
	res_t             acc_res;
	entry_t           acc_ent;
	entry_t           wr_ent;
	logic             out_load;
	res_t             out_nxt;

	assign it_idx   = IW'(it_slot_q);
	assign in_range = (32'(it_slot_q) < NUM_SLOTS);

	assign ent = valid_q[p_idx_s1] ? entry_t'(ram_rdata) : '0;
	assign v   = p_vld_s1 & valid_q[p_idx_s1];
	assign dec = v & (ent.delay != 16'd0);
	assign rel = v & (ent.delay == 16'd0);

	always_comb begin
		nxt = ent;
		if (dec) begin
			nxt.delay = ent.delay - 16'd1;
		end
		if (rel) begin
			nxt.delay = ent.period;
			if (ent.coop && ent.runs != 8'hFF) begin
				nxt.runs = ent.runs + 8'd1;
			end
		end
	end

	assign nxt_valid = ent.coop | (ent.period != 16'd0);

	always_comb begin
		rel_res       = '0;
		rel_res.slot  = 3'(p_idx_s1);
		rel_res.due   = 1'b1;
		rel_res.now   = ~ent.coop;
		rel_res.runs  = nxt.runs;
		rel_res.delay = nxt.delay;
		rel_res.occ   = nxt_valid;
	end

	assign emit     = rel & (cnt_q < CNT_W'(MAX_RES));
	assign out_free = ~out_vld_q | out_ready;
	assign stall    = emit & hold_vld_q & ~out_free;
	assign adv      = ~stall;

	assign acc_wr = cmd.acc_out & out_free & (it_func_q == FN_WRITE) & in_range;

	always_comb begin
		wr_ent        = '0;
		if (it_occ_q) begin
			wr_ent.delay  = it_delay_q;
			wr_ent.period = it_period_q;
			wr_ent.coop   = it_coop_q;
		end
	end

	always_comb begin
		acc_ent       = valid_q[it_idx] ? entry_t'(ram_rdata) : '0;
		acc_res       = '0;
		acc_res.slot  = it_slot_q;
		acc_res.last  = 1'b1;
		if (in_range) begin
			if (it_func_q == FN_WRITE) begin
				acc_res.delay = wr_ent.delay;
				acc_res.occ   = it_occ_q;
			end else begin
				acc_res.runs  = acc_ent.runs;
				acc_res.delay = acc_ent.delay;
				acc_res.occ   = valid_q[it_idx];
			end
		end
	end

	assign ram_we    = (adv & (dec | rel)) | acc_wr;
	assign ram_waddr = acc_wr ? it_idx : p_idx_s1;
	assign ram_wdata = acc_wr ? ENTRY_W'(wr_ent) : ENTRY_W'(nxt);
	assign ram_re    = (cmd.issue & adv) | (cmd.acc_rd & in_range);
	assign ram_raddr = cmd.issue ? walk_addr : it_idx;

	tts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		out_load = 1'b0;
		out_nxt  = hold_q;
		if (adv && emit && hold_vld_q) begin
			out_load = 1'b1;
		end else if (cmd.flush && hold_vld_q && out_free) begin
			out_load     = 1'b1;
			out_nxt.last = 1'b1;
		end else if (cmd.acc_out && out_free) begin
			out_load = 1'b1;
			out_nxt  = acc_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			it_func_q   <= in_func;
			it_slot_q   <= in_slot;
			it_delay_q  <= in_delay;
			it_period_q <= in_period;
			it_coop_q   <= in_coop;
			it_occ_q    <= in_occ;
		end
		if (adv) begin
			p_idx_s1 <= walk_addr;
		end
		if (adv && emit) begin
			hold_q      <= rel_res;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			p_vld_s1   <= 1'b0;
			cnt_q      <= '0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				p_vld_s1 <= cmd.issue;
			end
			if (adv && rel && !nxt_valid) begin
				valid_q[p_idx_s1] <= 1'b0;
			end
			if (acc_wr) begin
				valid_q[it_idx] <= it_occ_q;
			end
			if (cmd.take) begin
				cnt_q <= '0;
			end else if (adv && emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (adv && emit) begin
				hold_vld_q <= 1'b1;
			end else if (cmd.flush && out_free) begin
				hold_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts          = '0;
		sts.stall    = stall;
		sts.hold_vld = hold_vld_q;
		sts.out_free = out_free;
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;

endmodule

/* rtl/tick_task_release_scheduler_core.sv */
// Top level of the tick task release scheduler: stream ports, sequencer and datapath.
// Depends on tts_pkg, tts_ctrl, tts_dp and tts_ram.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata: slot, delay, period, coop, occupy
//                                               tuser: func
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata: result fields; tlast: last result
//
// A tick request walks one slot per cycle through the slot RAM read port while no held
// release waits on a full output register; a tail and a flush state follow the walk.
// Read and write requests use a slot read state, then an output state. A new request
// is taken once the previous one is done, even while its last result still waits in
// the output register. Reset clears the occupied flags at once; no clearing pass is run.
module tick_task_release_scheduler_core #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slot[2:0], start_delay[18:3], repeat_period[34:19], cooperative[35], occupy[36]
	input  logic [39:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// task_slot[2:0], fell_due[3], run_now[4], pending_runs[12:5], delay_left[28:13],
	// slot_occupied[29]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	import tts_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] walk_addr;
	res_t          res;

	tts_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.in_func   (s_axis_tuser),
		.sts       (sts),
		.cmd       (cmd),
		.walk_addr (walk_addr)
	);

	tts_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.walk_addr (walk_addr),
		.sts       (sts),
		.in_func   (s_axis_tuser),
		.in_slot   (s_axis_tdata[2:0]),
		.in_delay  (s_axis_tdata[18:3]),
		.in_period (s_axis_tdata[34:19]),
		.in_coop   (s_axis_tdata[35]),
		.in_occ    (s_axis_tdata[36]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res.occ, res.delay, res.runs, res.now, res.due, res.slot};
	assign m_axis_tlast = res.last;

endmodule

/* bench/tb.sv */
// Self-checking bench for tick_task_release_scheduler_core: random and directed slot
// writes, reads and ticks over the stream ports, checked against a slot-table predictor.
// Depends on tts_pkg and the RTL under rtl/.
module tb;
	import tts_pkg::*;

	localparam int         SLOTS   = NUM_SLOTS_DEF;
	localparam logic [1:0] FN_NONE = 2'd3;

	class release_board;
		logic        busy[SLOTS];
		logic [15:0] delay[SLOTS];
		logic [15:0] period[SLOTS];
		logic        coop[SLOTS];
		logic [7:0]  runs[SLOTS];
		res_t        due_results[$];
		int          mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				busy[i]   = 1'b0;
				delay[i]  = '0;
				period[i] = '0;
				coop[i]   = 1'b0;
				runs[i]   = '0;
			end
			mismatches = 0;
		endfunction

		function res_t view(int s, logic due, logic now, logic last);
			res_t r;
			r.slot  = 3'(s);
			r.due   = due;
			r.now   = now;
			r.runs  = runs[s];
			r.delay = delay[s];
			r.occ   = busy[s];
			r.last  = last;
			return r;
		endfunction

		function void note_request(logic [1:0] fn, logic [39:0] data);
			int   s;
			logic now;
			res_t rel[$];
			s = int'(data[2:0]);
			case (fn)
				FN_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!busy[i])
							continue;
						if (delay[i] != 16'd0) begin
							delay[i] = delay[i] - 16'd1;
							continue;
						end
						now = 1'b0;
						if (coop[i]) begin
							if (runs[i] != 8'hFF)
								runs[i] = runs[i] + 8'd1;
						end else begin
							now = 1'b1;
							if (period[i] == 16'd0)
								busy[i] = 1'b0;
						end
						if (period[i] != 16'd0)
							delay[i] = period[i];
						rel.push_back(view(i, 1'b1, now, 1'b0));
					end
					if (rel.size() > 0)
						rel[rel.size() - 1].last = 1'b1;
					foreach (rel[k])
						due_results.push_back(rel[k]);
				end
				FN_WRITE: begin
					if (data[36]) begin
						busy[s]   = 1'b1;
						delay[s]  = data[18:3];
						period[s] = data[34:19];
						coop[s]   = data[35];
					end else begin
						busy[s]   = 1'b0;
						delay[s]  = '0;
						period[s] = '0;
						coop[s]   = 1'b0;
					end
					runs[s] = '0;
					due_results.push_back(view(s, 1'b0, 1'b0, 1'b1));
				end
				FN_READ: due_results.push_back(view(s, 1'b0, 1'b0, 1'b1));
				default: ;
			endcase
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %s: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_result(logic [31:0] data, logic last);
			res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tdata %h tlast %b", data, last);
				return;
			end
			want = due_results.pop_front();
			compare("task_slot", 16'(want.slot), 16'(data[2:0]));
			compare("fell_due", 16'(want.due), 16'(data[3]));
			compare("run_now", 16'(want.now), 16'(data[4]));
			compare("pending_runs", 16'(want.runs), 16'(data[12:5]));
			compare("delay_left", want.delay, data[28:13]);
			compare("slot_occupied", 16'(want.occ), 16'(data[29]));
			compare("last", 16'(want.last), 16'(last));
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	release_board board;
	int           idle_pct;
	int           stall_pct;

	tick_task_release_scheduler_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [39:0] pack_request(logic [2:0] slot, logic [15:0] dl,
			logic [15:0] per, logic co, logic occ);
		return {3'b000, occ, co, per, dl, slot};
	endfunction

	task automatic send_request(input logic [1:0] fn, input logic [39:0] data);
		if (idle_pct > 0)
			while ($urandom_range(0, 99) < idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= fn;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_request(fn, data);
	endtask

	task automatic put_slot(input logic [2:0] slot, input logic [15:0] dl,
			input logic [15:0] per, input logic co, input logic occ);
		send_request(FN_WRITE, pack_request(slot, dl, per, co, occ));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// slot 7 holds a co-operative one-shot task; writes stay off it so its count saturates
	task automatic run_random(input int count);
		int          r;
		logic [15:0] dl;
		logic [15:0] per;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_request(FN_TICK, pack_request(3'($urandom_range(0, 7)), 16'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom)));
			end else if (r < 88) begin
				dl = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
				r = $urandom_range(0, 99);
				per = (r < 30) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 4)) : 16'($urandom);
				put_slot(3'($urandom_range(0, 6)), dl, per, 1'($urandom),
					$urandom_range(0, 99) < 85);
			end else if (r < 96) begin
				send_request(FN_READ, pack_request(3'($urandom_range(0, 7)), 16'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom)));
			end else begin
				send_request(FN_NONE, pack_request(3'($urandom_range(0, 7)), 16'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom)));
				n--;
			end
		end
	endtask

	initial begin
		#5000000;
		$display("tick_task_release_scheduler_core regression: fail");
		$finish;
	end

	initial begin
		board = new();
		idle_pct  = 0;
		stall_pct = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FN_TICK;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FN_READ, pack_request(3'd0, 16'd0, 16'd0, 1'b0, 1'b0));
		send_request(FN_TICK, '0);
		send_request(FN_NONE, pack_request(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		put_slot(3'd0, 16'd0, 16'd0, 1'b0, 1'b1);
		put_slot(3'd1, 16'd0, 16'd0, 1'b1, 1'b1);
		put_slot(3'd2, 16'd2, 16'd3, 1'b0, 1'b1);
		put_slot(3'd3, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		put_slot(3'd4, 16'd1, 16'd1, 1'b0, 1'b1);
		repeat (4) send_request(FN_TICK, '0);
		send_request(FN_READ, pack_request(3'd0, 16'd0, 16'd0, 1'b0, 1'b0));
		send_request(FN_READ, pack_request(3'd1, 16'd0, 16'd0, 1'b0, 1'b0));
		put_slot(3'd3, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		// every slot due at once
		for (int i = 0; i < SLOTS; i++)
			put_slot(3'(i), 16'd0, 16'd1, 1'(i), 1'b1);
		repeat (2) send_request(FN_TICK, '0);
		put_slot(3'd7, 16'd0, 16'd0, 1'b1, 1'b1);
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct  = (p == 1) ? 49 : (p == 3) ? 8 : 0;
			stall_pct = (p == 2) ? 49 : (p == 3) ? 8 : 0;
			run_random(100);
			drain();
		end
		send_request(FN_READ, pack_request(3'd7, 16'd0, 16'd0, 1'b0, 1'b0));
		drain();
		repeat (40) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("tick_task_release_scheduler_core regression: pass");
		else
			$display("tick_task_release_scheduler_core regression: fail");
		$finish;
	end
endmodule
